// File: rtl/rtdsd_pkg.sv
// Shared types and constants for the RTD settle detector.
// Used by every file of the block; depends on nothing.
package rtdsd_pkg;

    // Fixed field widths
    localparam int RES_W      = 25;   // resistance reading, unsigned
    localparam int OUT_W      = 28;   // temperature and step, signed
    localparam int DIFF_W     = OUT_W + 1;
    localparam int TGT_W      = 27;   // target temperature, signed
    localparam int STEP_TOL_W = 20;
    localparam int TGT_TOL_W  = 24;
    localparam int CNT_TGT_W  = 16;
    localparam int RUN_W      = 16;   // reported run count

    // Horner datapath: 64 bit signed accumulator, 63 bit magnitude
    localparam int ACC_W      = 64;
    localparam int MAG_W      = ACC_W - 1;
    localparam int LIMIT_BIT  = 62;   // magnitude of each product step saturates to 2^62
    localparam int COEF_SCALE = 48;   // coefficients are scaled by 2^48

    localparam logic [MAG_W-1:0] ACC_LIMIT = MAG_W'(1) << LIMIT_BIT;

    // Cubic coefficients, constant term first
    localparam logic signed [ACC_W-1:0] POLY_COEF [0:3] = '{
        -64'sd69338799090382039,
         64'sd670262288292250,
         64'sd209913031959,
         64'sd225979539
    };

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TOL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TOL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_TARGET = 2'd3;

    // Register reset values
    localparam logic signed [TGT_W-1:0]   TARGET_TEMP_RST  = 27'sd1638400;
    localparam logic [STEP_TOL_W-1:0]     STEP_TOL_RST     = 20'd328;
    localparam logic [TGT_TOL_W-1:0]      TARGET_TOL_RST   = 24'd65536;
    localparam logic [CNT_TGT_W-1:0]      COUNT_TARGET_RST = 16'd300;

endpackage

// File: rtl/rtdsd_ser_mul.sv
// Serial-parallel multiplier: 63 bit magnitude times 25 bit reading, one reading bit
// per cycle, then round to nearest and saturate to 2^62. Depends on rtdsd_pkg.
module rtdsd_ser_mul
    import rtdsd_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [MAG_W-1:0] mult,    // held stable until done
    input  logic [RES_W-1:0] mcand,   // sampled at start
    output logic             done,
    output logic [MAG_W-1:0] res
);

    localparam int PROD_W = MAG_W + 1 + RES_W;
    localparam int CNT_W  = $clog2(RES_W);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_RND  = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [MAG_W:0]    h_reg, h_next;
    logic [RES_W-1:0]  l_reg, l_next;
    logic [RES_W-1:0]  b_reg, b_next;
    logic [MAG_W-1:0]  res_reg, res_next;

    logic [MAG_W:0]    sum;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] shf;
    logic              rnd_bit;
    logic              sat;

    assign sum     = h_reg + (b_reg[0] ? {1'b0, mult} : '0);
    assign prod    = {h_reg, l_reg};
    assign shf     = prod >> FRACTION_BITS;
    assign rnd_bit = prod[FRACTION_BITS-1];
    assign sat     = |shf[PROD_W-1:LIMIT_BIT];

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        h_next     = h_reg;
        l_next     = l_reg;
        b_next     = b_reg;
        res_next   = res_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    h_next     = '0;
                    l_next     = '0;
                    b_next     = mcand;
                    cnt_next   = '0;
                    phase_next = PH_MUL;
                end
            end
            PH_MUL: begin
                // product shifts right; low bits drop into l_reg
                h_next = {1'b0, sum[MAG_W:1]};
                l_next = {sum[0], l_reg[RES_W-1:1]};
                b_next = {1'b0, b_reg[RES_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RES_W - 1)) begin
                    phase_next = PH_RND;
                end
            end
            PH_RND: begin
                // ties away from zero on the magnitude
                res_next   = sat ? ACC_LIMIT
                                 : {1'b0, shf[LIMIT_BIT-1:0]} + MAG_W'(rnd_bit);
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        h_reg   <= h_next;
        l_reg   <= l_next;
        b_reg   <= b_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: rtl/rtd_temperature_settle_detector_core.sv
// Top level of the RTD settle detector: cubic conversion sequencer, step and target
// checks, run counter and result register. Depends on rtdsd_pkg and rtdsd_ser_mul.
//
//  port group   direction  contents
//  s_*          in         resistance (Q9.16 ohms), restart
//  m_*          out        temperature, temperature_step, run_count, settled
//  cfg_wr_*     in         register writes, no read-back
//
// Each item runs three Horner steps, each one paced by the bit-serial multiplier
// walking the 25 bit reading, then final rounding, saturation, difference and
// comparison (S_FRND to S_CMP). Reset is synchronous, active low; control and
// configuration registers return to their documented values. A new item is taken
// as soon as the previous one has been written to the output register; if that
// register is still held by the sink, the block waits before it.
module rtd_temperature_settle_detector_core
    import rtdsd_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int COUNT_BITS    = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [RES_W-1:0]             s_resistance,
    input  logic                         s_restart,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [OUT_W-1:0]      m_temperature,
    output logic signed [OUT_W-1:0]      m_temperature_step,
    output logic [RUN_W-1:0]             m_run_count,
    output logic                         m_settled,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wr_data
);

    localparam int FIN_SH = COEF_SCALE - FRACTION_BITS;
    localparam logic [ACC_W-1:0] FIN_HALF = ACC_W'(1) << (FIN_SH - 1);
    localparam logic [ACC_W-1:0] POS_LIM  = (ACC_W'(1) << (OUT_W - 1)) - ACC_W'(1);
    localparam logic [ACC_W-1:0] NEG_LIM  = ACC_W'(1) << (OUT_W - 1);
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam int NW = (COUNT_BITS + 1 > CNT_TGT_W + 1) ? COUNT_BITS + 1 : CNT_TGT_W + 1;
    localparam logic [NW-1:0] CNT_MAX = NW'({COUNT_BITS{1'b1}});

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAG  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_FRND = 3'd3;
    localparam logic [2:0] S_FSAT = 3'd4;
    localparam logic [2:0] S_DIFF = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;

    // control
    logic [2:0]                 state_reg, state_next;
    logic [1:0]                 k_reg, k_next;
    logic                       fin_reg, fin_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0]    prev_reg, prev_next;
    logic [COUNT_BITS-1:0]      count_reg, count_next;
    logic signed [TGT_W-1:0]    tgt_temp_reg, tgt_temp_next;
    logic [STEP_TOL_W-1:0]      step_tol_reg, step_tol_next;
    logic [TGT_TOL_W-1:0]       tgt_tol_reg, tgt_tol_next;
    logic [CNT_TGT_W-1:0]       cnt_tgt_reg, cnt_tgt_next;

    // datapath
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic                       neg_reg, neg_next;
    logic [RES_W-1:0]           r_reg, r_next;
    logic [ACC_W-1:0]           rmag_reg, rmag_next;
    logic signed [OUT_W-1:0]    t_reg, t_next;
    logic signed [DIFF_W-1:0]   step_reg, step_next;
    logic signed [DIFF_W-1:0]   dist_reg, dist_next;
    logic signed [OUT_W-1:0]    m_temp_reg, m_temp_next;
    logic signed [OUT_W-1:0]    m_step_reg, m_step_next;
    logic [RUN_W-1:0]           m_run_reg, m_run_next;
    logic                       m_settled_reg, m_settled_next;

    logic                       mul_start;
    logic                       mul_done;
    logic [MAG_W-1:0]           mul_res;
    logic signed [ACC_W-1:0]    coef;
    logic signed [ACC_W-1:0]    prod_s;
    logic [DIFF_W-1:0]          abs_step;
    logic [DIFF_W-1:0]          abs_dist;
    logic                       in_tol;
    logic [NW-1:0]              cnt_inc;
    logic [NW-1:0]              cnt_new;
    logic                       out_free;

    rtdsd_ser_mul #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .mult   (mag_reg),
        .mcand  (r_reg),
        .done   (mul_done),
        .res    (mul_res)
    );

    assign mul_start = (state_reg == S_MAG) && !fin_reg;
    assign coef      = POLY_COEF[k_reg];
    assign prod_s    = $signed({1'b0, mul_res});
    assign out_free  = !m_valid_reg || m_ready;

    assign abs_step = step_reg[DIFF_W-1] ? DIFF_W'(-step_reg) : DIFF_W'(step_reg);
    assign abs_dist = dist_reg[DIFF_W-1] ? DIFF_W'(-dist_reg) : DIFF_W'(dist_reg);
    assign in_tol   = (abs_step < DIFF_W'(step_tol_reg)) && (abs_dist < DIFF_W'(tgt_tol_reg));

    always_comb begin
        cnt_inc = NW'(count_reg) + NW'(1);
        if (cnt_inc > NW'(cnt_tgt_reg)) begin
            cnt_inc = NW'(cnt_tgt_reg);
        end
        if (cnt_inc > CNT_MAX) begin
            cnt_inc = CNT_MAX;
        end
        cnt_new = in_tol ? cnt_inc : '0;
    end

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        fin_next       = fin_reg;
        m_valid_next   = m_valid_reg;
        prev_next      = prev_reg;
        count_next     = count_reg;
        tgt_temp_next  = tgt_temp_reg;
        step_tol_next  = step_tol_reg;
        tgt_tol_next   = tgt_tol_reg;
        cnt_tgt_next   = cnt_tgt_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        r_next         = r_reg;
        rmag_next      = rmag_reg;
        t_next         = t_reg;
        step_next      = step_reg;
        dist_next      = dist_reg;
        m_temp_next    = m_temp_reg;
        m_step_next    = m_step_reg;
        m_run_next     = m_run_reg;
        m_settled_next = m_settled_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_TARGET_TEMP:  tgt_temp_next = $signed(cfg_wr_data[TGT_W-1:0]);
                REG_STEP_TOL:     step_tol_next = cfg_wr_data[STEP_TOL_W-1:0];
                REG_TARGET_TOL:   tgt_tol_next  = cfg_wr_data[TGT_TOL_W-1:0];
                REG_COUNT_TARGET: cnt_tgt_next  = cfg_wr_data[CNT_TGT_W-1:0];
                default: begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    r_next     = s_resistance;
                    acc_next   = POLY_COEF[3];
                    k_next     = 2'd2;
                    fin_next   = 1'b0;
                    state_next = S_MAG;
                    if (s_restart) begin
                        prev_next  = '0;
                        count_next = '0;
                    end
                end
            end
            S_MAG: begin
                neg_next   = acc_reg[ACC_W-1];
                mag_next   = acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : acc_reg[MAG_W-1:0];
                state_next = fin_reg ? S_FRND : S_MUL;
            end
            S_MUL: begin
                if (mul_done) begin
                    acc_next   = neg_reg ? coef - prod_s : coef + prod_s;
                    state_next = S_MAG;
                    if (k_reg == 2'd0) begin
                        fin_next = 1'b1;
                    end else begin
                        k_next = k_reg - 2'd1;
                    end
                end
            end
            S_FRND: begin
                rmag_next  = ({1'b0, mag_reg} + FIN_HALF) >> FIN_SH;
                state_next = S_FSAT;
            end
            S_FSAT: begin
                if (!neg_reg) begin
                    t_next = (rmag_reg > POS_LIM) ? OUT_MAX : $signed(rmag_reg[OUT_W-1:0]);
                end else begin
                    t_next = (rmag_reg > NEG_LIM) ? OUT_MIN : $signed(-rmag_reg[OUT_W-1:0]);
                end
                state_next = S_DIFF;
            end
            S_DIFF: begin
                step_next  = $signed({t_reg[OUT_W-1], t_reg}) - $signed({prev_reg[OUT_W-1], prev_reg});
                dist_next  = $signed({t_reg[OUT_W-1], t_reg})
                           - $signed({{(DIFF_W-TGT_W){tgt_temp_reg[TGT_W-1]}}, tgt_temp_reg});
                state_next = S_CMP;
            end
            S_CMP: begin
                if (out_free) begin
                    prev_next      = t_reg;
                    count_next     = cnt_new[COUNT_BITS-1:0];
                    m_temp_next    = t_reg;
                    // report the step saturated to the output range
                    if (step_reg[DIFF_W-1] != step_reg[DIFF_W-2]) begin
                        m_step_next = step_reg[DIFF_W-1] ? OUT_MIN : OUT_MAX;
                    end else begin
                        m_step_next = step_reg[OUT_W-1:0];
                    end
                    m_run_next     = cnt_new[RUN_W-1:0];
                    m_settled_next = cnt_new >= NW'(cnt_tgt_reg);
                    m_valid_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            fin_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            prev_reg     <= '0;
            count_reg    <= '0;
            tgt_temp_reg <= TARGET_TEMP_RST;
            step_tol_reg <= STEP_TOL_RST;
            tgt_tol_reg  <= TARGET_TOL_RST;
            cnt_tgt_reg  <= COUNT_TARGET_RST;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            fin_reg      <= fin_next;
            m_valid_reg  <= m_valid_next;
            prev_reg     <= prev_next;
            count_reg    <= count_next;
            tgt_temp_reg <= tgt_temp_next;
            step_tol_reg <= step_tol_next;
            tgt_tol_reg  <= tgt_tol_next;
            cnt_tgt_reg  <= cnt_tgt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg       <= acc_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        r_reg         <= r_next;
        rmag_reg      <= rmag_next;
        t_reg         <= t_next;
        step_reg      <= step_next;
        dist_reg      <= dist_next;
        m_temp_reg    <= m_temp_next;
        m_step_reg    <= m_step_next;
        m_run_reg     <= m_run_next;
        m_settled_reg <= m_settled_next;
    end

    assign s_ready            = (state_reg == S_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_temperature      = m_temp_reg;
    assign m_temperature_step = m_step_reg;
    assign m_run_count        = m_run_reg;
    assign m_settled          = m_settled_reg;

endmodule

// File: rtl/rtdsd_chk.sv
// Port-level assertions for the RTD settle detector, bound to the top level.
// Depends on rtdsd_pkg and rtd_temperature_settle_detector_core.
module rtdsd_chk
    import rtdsd_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [OUT_W-1:0] m_temperature,
    input logic signed [OUT_W-1:0] m_temperature_step,
    input logic [RUN_W-1:0]        m_run_count,
    input logic                    m_settled
);

    // a stalled result keeps its item unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temperature)
            && $stable(m_temperature_step) && $stable(m_run_count) && $stable(m_settled))
        else $error("result changed while stalled");

    // one item in flight: input closes right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while busy");

    // a result is published only once the sequencer is back at rest
    a_rose_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result appeared with sequencer busy");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind rtd_temperature_settle_detector_core rtdsd_chk u_rtdsd_chk (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_temperature     (m_temperature),
    .m_temperature_step(m_temperature_step),
    .m_run_count       (m_run_count),
    .m_settled         (m_settled)
);

// File: sim/rtd_temperature_settle_detector_core_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the RTD settle detector: watches the reading and result channels and the
// register port, predicts every reading's result and compares it field by field.
// Depends on rtdsd_pkg.
module rtd_temperature_settle_detector_core_checker
    import rtdsd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [RES_W-1:0]        s_resistance,
    input  logic                    s_restart,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [OUT_W-1:0] m_temperature,
    input  logic signed [OUT_W-1:0] m_temperature_step,
    input  logic [RUN_W-1:0]        m_run_count,
    input  logic                    m_settled,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wr_data,
    output int                      fail_count,
    output int                      outstanding
);

    localparam int     FRAC         = 16;
    localparam int     RUN_LEN_BITS = 16;
    localparam int     SCALE_SHIFT  = 48 - FRAC;
    localparam longint RUN_CAP      = (longint'(1) << RUN_LEN_BITS) - 1;
    localparam longint DEGC_MAX     = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint DEGC_MIN     = -(longint'(1) << (OUT_W - 1));
    // cubic in ohms, coefficients scaled by 2^48, constant term first
    localparam longint CUBIC [0:3] = '{
        -64'sd69338799090382039,
         64'sd670262288292250,
         64'sd209913031959,
         64'sd225979539
    };

    typedef struct {
        logic signed [OUT_W-1:0] degc;
        logic signed [OUT_W-1:0] step;
        logic [RUN_W-1:0]        run_count;
        logic                    settled;
    } reading_result_t;

    reading_result_t expected_readings[$];

    longint target_degc;
    longint step_tol;
    longint target_tol;
    longint count_target;
    longint last_degc;
    longint run_len;

    task automatic report_fault(input string msg);
        $display("%0t ns: mismatch, %s", $time, msg);
        fail_count++;
    endtask

    // round(acc * r / 2^FRAC), ties away from zero, magnitude capped at 2^62
    function automatic longint horner_mul(input longint acc, input logic [RES_W-1:0] r);
        logic [127:0] prod;
        logic [63:0]  m;
        m = (acc < 0) ? 64'(-acc) : 64'(acc);
        prod = 128'(m) * 128'(r);
        prod = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
        if (prod > (128'd1 << 62)) begin
            prod = 128'd1 << 62;
        end
        return (acc < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic longint clamp_degc(input longint v);
        if (v > DEGC_MAX) begin
            return DEGC_MAX;
        end
        if (v < DEGC_MIN) begin
            return DEGC_MIN;
        end
        return v;
    endfunction

    function automatic longint degc_of(input logic [RES_W-1:0] r);
        longint      acc;
        logic [63:0] m;
        int          k;
        acc = CUBIC[3];
        for (k = 2; k >= 0; k--) begin
            acc = horner_mul(acc, r) + CUBIC[k];
        end
        m = (acc < 0) ? 64'(-acc) : 64'(acc);
        m = (m + (64'd1 << (SCALE_SHIFT - 1))) >> SCALE_SHIFT;
        return clamp_degc((acc < 0) ? -longint'(m) : longint'(m));
    endfunction

    function automatic reading_result_t predict_reading(input logic [RES_W-1:0] r,
                                                        input logic restart);
        reading_result_t res;
        longint          t;
        longint          step;
        longint          target_gap;
        logic            in_band;
        if (restart) begin
            last_degc = 0;
            run_len   = 0;
        end
        t = degc_of(r);
        step = t - last_degc;
        target_gap = t - target_degc;
        last_degc = t;
        in_band = (((step < 0) ? -step : step) < step_tol) &&
                  (((target_gap < 0) ? -target_gap : target_gap) < target_tol);
        if (in_band) begin
            run_len = run_len + 1;
            if (run_len > count_target) begin
                run_len = count_target;
            end
            if (run_len > RUN_CAP) begin
                run_len = RUN_CAP;
            end
        end else begin
            run_len = 0;
        end
        res.degc      = OUT_W'(t);
        res.step      = OUT_W'(clamp_degc(step));
        res.run_count = RUN_W'(run_len);
        res.settled   = (run_len >= count_target);
        return res;
    endfunction

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin : track
        reading_result_t want;
        if (!aresetn) begin
            target_degc  = 1638400;
            step_tol     = 328;
            target_tol   = 65536;
            count_target = 300;
            last_degc    = 0;
            run_len      = 0;
            expected_readings.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_TARGET_TEMP:  target_degc  = longint'($signed(cfg_wr_data[TGT_W-1:0]));
                    REG_STEP_TOL:     step_tol     = longint'(cfg_wr_data[STEP_TOL_W-1:0]);
                    REG_TARGET_TOL:   target_tol   = longint'(cfg_wr_data[TGT_TOL_W-1:0]);
                    REG_COUNT_TARGET: count_target = longint'(cfg_wr_data[CNT_TGT_W-1:0]);
                    default: ;
                endcase
            end
            // results leave before the new reading is queued
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    report_fault($sformatf("result with no reading pending, temperature %0d",
                                           m_temperature));
                end else begin
                    want = expected_readings.pop_front();
                    if (m_temperature !== want.degc) begin
                        report_fault($sformatf("temperature got %0d expected %0d",
                                               m_temperature, want.degc));
                    end
                    if (m_temperature_step !== want.step) begin
                        report_fault($sformatf("temperature_step got %0d expected %0d",
                                               m_temperature_step, want.step));
                    end
                    if (m_run_count !== want.run_count) begin
                        report_fault($sformatf("run_count got %0d expected %0d",
                                               m_run_count, want.run_count));
                    end
                    if (m_settled !== want.settled) begin
                        report_fault($sformatf("settled got %0b expected %0b",
                                               m_settled, want.settled));
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_readings.insert(expected_readings.size(),
                                         predict_reading(s_resistance, s_restart));
            end
        end
        outstanding = expected_readings.size();
    end

endmodule

// File: sim/rtd_temperature_settle_detector_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the RTD settle detector: clock, reset, reading and register stimulus,
// random back-pressure and the verdict. Depends on rtdsd_pkg, the core and the checker module.
module rtd_temperature_settle_detector_core_tb;
    import rtdsd_pkg::*;

    localparam int READING_TOTAL  = 1450;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_WAIT    = 100;
    localparam int RES_MAX        = (1 << RES_W) - 1;
    localparam int R_ROOM         = 7191265;       // about 109.73 ohm, close to 25 degC
    localparam int TARGET_LOW     = -13107200;     // -200 degC
    localparam int TARGET_HIGH    = 55705600;      // 850 degC
    localparam int TARGET_MIN     = -(1 << (TGT_W - 1));
    localparam int TARGET_MAX     = (1 << (TGT_W - 1)) - 1;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [RES_W-1:0]        s_resistance;
    logic                    s_restart;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [OUT_W-1:0] m_temperature;
    logic signed [OUT_W-1:0] m_temperature_step;
    logic [RUN_W-1:0]        m_run_count;
    logic                    m_settled;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_wr_index;
    logic [CFG_DATA_W-1:0]   cfg_wr_data;
    int                      fail_count;
    int                      outstanding;
    int                      readings_sent;
    logic                    steady_flow;

    rtd_temperature_settle_detector_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_resistance       (s_resistance),
        .s_restart          (s_restart),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_temperature      (m_temperature),
        .m_temperature_step (m_temperature_step),
        .m_run_count        (m_run_count),
        .m_settled          (m_settled),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_index       (cfg_wr_index),
        .cfg_wr_data        (cfg_wr_data)
    );

    rtd_temperature_settle_detector_core_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_resistance       (s_resistance),
        .s_restart          (s_restart),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_temperature      (m_temperature),
        .m_temperature_step (m_temperature_step),
        .m_run_count        (m_run_count),
        .m_settled          (m_settled),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_index       (cfg_wr_index),
        .cfg_wr_data        (cfg_wr_data),
        .fail_count         (fail_count),
        .outstanding        (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return steady_flow ? 0 : int'($urandom_range(0, 4));
    endfunction

    // rough degC of a Q9.16 reading, only used to aim the target register
    function automatic real approx_degc(input int r);
        real ohms;
        ohms = r / 65536.0;
        return -246.3409 + ohms * (2.381250 + ohms * (7.457609e-4 + ohms * 8.028406e-7));
    endfunction

    function automatic logic [RES_W-1:0] clamp_res(input int v);
        if (v < 0) begin
            return '0;
        end
        if (v > RES_MAX) begin
            return RES_W'(RES_MAX);
        end
        return RES_W'(v);
    endfunction

    task automatic push_reading(input logic [RES_W-1:0] res, input logic restart);
        int gap;
        gap = draw_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_resistance = res;
        s_restart    = restart;
        do @(posedge aclk); while (s_ready !== 1'b1);
        readings_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = CFG_DATA_W'(value);
        @(negedge aclk);
        cfg_wr_en    = 1'b0;
    endtask

    // one oven episode: aim the target at a base reading, then jitter around it
    task automatic run_episode();
        int r0;
        int jit;
        int st;
        int tt;
        int ct;
        int tgt;
        int n;
        int k;
        int i;
        logic restart;
        drain();
        if ($urandom_range(0, 7) == 0) begin
            r0 = $urandom_range(0, RES_MAX);
        end else begin
            r0 = $urandom_range(40 << 16, 400 << 16);
        end
        case ($urandom_range(0, 9))
            0:       ct = 0;
            1:       ct = 65535;
            2:       ct = 300;
            3, 4, 5: ct = $urandom_range(1, 6);
            default: ct = $urandom_range(7, 40);
        endcase
        case ($urandom_range(0, 9))
            0:       st = 0;
            1:       st = (1 << STEP_TOL_W) - 1;
            default: st = $urandom_range(100, 20000);
        endcase
        case ($urandom_range(0, 9))
            0:       tt = 0;
            1:       tt = (1 << TGT_TOL_W) - 1;
            default: tt = $urandom_range(1000, 300000);
        endcase
        tgt = $rtoi(approx_degc(r0) * 65536.0) + int'($urandom_range(0, tt / 2)) - tt / 4;
        case ($urandom_range(0, 15))
            0:       tgt = TARGET_LOW;
            1:       tgt = TARGET_HIGH;
            default: ;
        endcase
        if (tgt < TARGET_MIN) tgt = TARGET_MIN;
        if (tgt > TARGET_MAX) tgt = TARGET_MAX;
        if ($urandom_range(0, 3) != 0) set_reg(REG_TARGET_TEMP, tgt);
        if ($urandom_range(0, 3) != 0) set_reg(REG_STEP_TOL, st);
        if ($urandom_range(0, 3) != 0) set_reg(REG_TARGET_TOL, tt);
        if ($urandom_range(0, 3) != 0) set_reg(REG_COUNT_TARGET, ct);
        jit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 300);
        steady_flow = ($urandom_range(0, 3) == 0);
        n = $urandom_range(15, 60);
        for (i = 0; i < n && readings_sent < READING_TOTAL; i++) begin
            k = $urandom_range(0, 99);
            if (k < 7) begin
                push_reading(RES_W'($urandom_range(0, RES_MAX)), 1'($urandom_range(0, 1)));
            end else if (k < 12) begin
                push_reading(clamp_res(r0 + int'($urandom_range(0, 1 << 18)) - (1 << 17)),
                             1'b0);
            end else begin
                restart = (k < 15) || (i == 0 && $urandom_range(0, 1) == 1);
                push_reading(clamp_res(r0 + int'($urandom_range(0, 2 * jit)) - jit), restart);
            end
        end
    endtask

    // result side: random stall before each item
    initial begin : sink
        int gap;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            gap = draw_gap();
            if (gap != 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_resistance  = '0;
        s_restart     = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = REG_TARGET_TEMP;
        cfg_wr_data   = '0;
        readings_sent = 0;
        steady_flow   = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings; first reading after reset sees a previous temperature of zero
        push_reading('0, 1'b0);
        push_reading(RES_W'(RES_MAX), 1'b0);
        push_reading(RES_W'(RES_MAX), 1'b1);
        push_reading(RES_W'(1), 1'b0);
        push_reading(25'h1555555, 1'b0);
        push_reading(25'h0AAAAAA, 1'b1);
        push_reading(RES_W'(R_ROOM), 1'b1);
        push_reading(RES_W'(R_ROOM), 1'b0);

        // short count target: count climbs, saturates, then a jump and a restart clear it
        drain();
        set_reg(REG_TARGET_TEMP, $rtoi(approx_degc(R_ROOM) * 65536.0));
        set_reg(REG_STEP_TOL, 1000);
        set_reg(REG_TARGET_TOL, 65536);
        set_reg(REG_COUNT_TARGET, 3);
        repeat (5) push_reading(RES_W'(R_ROOM), 1'b0);
        push_reading(RES_W'(R_ROOM + 65536), 1'b0);
        push_reading(RES_W'(R_ROOM), 1'b1);

        // zero count target: always settled
        drain();
        set_reg(REG_COUNT_TARGET, 0);
        set_reg(REG_TARGET_TEMP, TARGET_MIN);
        set_reg(REG_STEP_TOL, 0);
        set_reg(REG_TARGET_TOL, (1 << TGT_TOL_W) - 1);
        push_reading(RES_W'(R_ROOM), 1'b0);
        push_reading(RES_W'(R_ROOM), 1'b0);

        drain();
        set_reg(REG_TARGET_TEMP, TARGET_MAX);
        set_reg(REG_STEP_TOL, (1 << STEP_TOL_W) - 1);
        set_reg(REG_TARGET_TOL, 0);
        set_reg(REG_COUNT_TARGET, 65535);
        push_reading(RES_W'(R_ROOM), 1'b0);
        push_reading(RES_W'(R_ROOM), 1'b0);

        // wide tolerances, count target of one
        drain();
        set_reg(REG_TARGET_TOL, (1 << TGT_TOL_W) - 1);
        set_reg(REG_COUNT_TARGET, 1);
        repeat (3) push_reading(RES_W'(R_ROOM), 1'b0);

        while (readings_sent < READING_TOTAL) run_episode();

        drain();
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
